@@ hw/rtl/sample_mean_and_std_dev_defines.svh @@
// assertion macros for the sample mean and deviation block
// used by files that check their own logic; expects clk and arst_n in scope
`ifndef SAMPLE_MEAN_AND_STD_DEV_DEFINES_SVH
`define SAMPLE_MEAN_AND_STD_DEV_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SMSD_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("smsd assertion failed");
`define SMSD_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("smsd reset assertion failed");
`else
`define SMSD_ASSERT(lbl, prop)
`define SMSD_ASSERT_RST(lbl, prop)
`endif
`endif

@@ hw/rtl/smsd_pkg.sv @@
// shared types and constants for the sample mean and deviation block
// no dependencies
package smsd_pkg;

	localparam int SAMPLE_W = 32;
	localparam int RESULT_W = 32;

	typedef enum logic [2:0] {
		S_LOAD,
		S_MEAN_GO,
		S_MEAN_WAIT,
		S_PASS,
		S_VAR_GO,
		S_VAR_WAIT,
		S_SQRT_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

@@ hw/rtl/smsd_store.sv @@
// sample store: one write port, one read port with registered read data
// depends on smsd_pkg
module smsd_store import smsd_pkg::*; #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  logic [SAMPLE_W-1:0] wdata,
	input  logic                re,
	input  logic [AW-1:0]       raddr,
	output logic [SAMPLE_W-1:0] rdata
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/smsd_div.sv @@
// unsigned restoring divider, one quotient bit per cycle
// depends on smsd_pkg
module smsd_div import smsd_pkg::*; #(
	parameter int DW = 74,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output unit_stat_t    stat
);

	localparam int NW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [NW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   sh;
	logic          fits;

	assign sh   = {rem_q, quo_q[DW-1]};
	assign fits = sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DW-2:0], fits};
			rem_q <= fits ? VW'(sh - {1'b0, dvs_q}) : sh[VW-1:0];
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ hw/rtl/smsd_sqrt.sv @@
// integer square root, one result bit per cycle
// depends on smsd_pkg
module smsd_sqrt import smsd_pkg::*; #(
	parameter int RW = 37
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            go,
	input  logic [2*RW-1:0] radicand,
	output logic [RW-1:0]   root,
	output unit_stat_t      stat
);

	localparam int NW = $clog2(RW + 1);

	logic [2*RW-1:0] rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [NW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW+2:0]   sh;
	logic [RW+2:0]   trial;
	logic            fits;

	assign sh    = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = {1'b0, root_q, 2'b01};
	assign fits  = sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[2*RW-3:0], 2'b00};
			rem_q  <= fits ? (RW+1)'(sh - trial) : sh[RW:0];
			root_q <= {root_q[RW-2:0], fits};
		end
	end

	assign root      = root_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

@@ hw/rtl/sample_mean_and_std_dev.sv @@
// top level of the sample mean and sample standard deviation block
// depends on smsd_pkg, smsd_store, smsd_div, smsd_sqrt and the defines header
//
// Samples are taken one per cycle while busy is low; each kept sample is written
// to the sample store and added to a running sum. The sample with is_last closes
// the set and raises busy. The mean is then computed in the shared bit-serial
// divider, the second pass reads the store at one sample per cycle, the variance
// is divided in the same divider, and then the square root is taken. The result
// appears for exactly one cycle with done high and is not held, so the receiver
// must take it then. Samples beyond MAX_SAMPLES are dropped and flagged.
`include "sample_mean_and_std_dev_defines.svh"
module sample_mean_and_std_dev import smsd_pkg::*; #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [SAMPLE_W-1:0]           sample,
	input  logic                                 is_last,
	output logic                                 done,
	output logic signed [RESULT_W-1:0]           mean_value,
	output logic [RESULT_W-1:0]                  std_dev,
	output logic [$clog2(MAX_SAMPLES+1)-1:0]     sample_total,
	output logic                                 too_few,
	output logic                                 overflowed
);

	localparam int AW   = $clog2(MAX_SAMPLES);
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SW   = SAMPLE_W + AW;
	localparam int ACCW = 2 * SAMPLE_W + AW;
	localparam int RW   = (ACCW + 1) / 2;

	state_t state_q, state_d;

	logic [CW-1:0]          count_q;
	logic signed [SW-1:0]   sum_q;
	logic                   drop_q;
	logic [CW-1:0]          idx_q;
	logic [ACCW-1:0]        acc_q;
	logic [RESULT_W-1:0]    mean_q;
	logic [RESULT_W-1:0]    dev_q;

	logic                   v_s1, v_s2, v_s3;
	logic [SAMPLE_W-1:0]    mag_s2;
	logic [2*SAMPLE_W-1:0]  sq_s3;

	logic                   take;
	logic                   room;
	logic                   issue;
	logic                   pass_end;
	logic                   div_go;
	logic                   sqrt_go;
	logic [ACCW-1:0]        div_num;
	logic [CW-1:0]          div_den;
	logic [ACCW-1:0]        quo;
	logic [RW-1:0]          root;
	unit_stat_t             div_stat;
	unit_stat_t             sqrt_stat;
	logic [SAMPLE_W-1:0]    rdata;
	logic [SW-1:0]          abs_sum;
	logic [SAMPLE_W:0]      diff;
	logic [RESULT_W-1:0]    q32;

	assign take     = start && !busy;
	assign room     = count_q < CW'(MAX_SAMPLES);
	assign issue    = (state_q == S_PASS) && (idx_q < count_q);
	assign pass_end = (state_q == S_PASS) && !issue && !v_s1 && !v_s2 && !v_s3;
	assign abs_sum  = sum_q[SW-1] ? SW'(-sum_q) : SW'(sum_q);
	assign div_num  = (state_q == S_MEAN_GO) ? ACCW'(abs_sum) : acc_q;
	assign div_den  = (state_q == S_MEAN_GO) ? count_q : count_q - 1'b1;
	assign diff     = {rdata[SAMPLE_W-1], rdata} - {mean_q[RESULT_W-1], mean_q};
	assign q32      = quo[RESULT_W-1:0];

	smsd_store #(.DEPTH(MAX_SAMPLES), .AW(AW)) u_store (
		.clk   (clk),
		.we    (take && room),
		.waddr (count_q[AW-1:0]),
		.wdata (sample),
		.re    (issue),
		.raddr (idx_q[AW-1:0]),
		.rdata (rdata)
	);

	smsd_div #(.DW(ACCW), .VW(CW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (div_go),
		.dividend (div_num),
		.divisor  (div_den),
		.quotient (quo),
		.stat     (div_stat)
	);

	smsd_sqrt #(.RW(RW)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (sqrt_go),
		.radicand ((2*RW)'(quo)),
		.root     (root),
		.stat     (sqrt_stat)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_LOAD: begin
				if (take && is_last) state_d = S_MEAN_GO;
			end
			S_MEAN_GO: state_d = S_MEAN_WAIT;
			S_MEAN_WAIT: begin
				if (div_stat.done) state_d = (count_q < CW'(2)) ? S_DONE : S_PASS;
			end
			S_PASS: begin
				if (pass_end) state_d = S_VAR_GO;
			end
			S_VAR_GO: state_d = S_VAR_WAIT;
			S_VAR_WAIT: begin
				if (div_stat.done) state_d = S_SQRT_WAIT;
			end
			S_SQRT_WAIT: begin
				if (sqrt_stat.done) state_d = S_DONE;
			end
			S_DONE: state_d = S_LOAD;
			default: state_d = S_LOAD;
		endcase
	end

	// unit controls and handshake outputs
	always_comb begin
		div_go  = 1'b0;
		sqrt_go = 1'b0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			S_LOAD:      busy = 1'b0;
			S_MEAN_GO:   div_go = 1'b1;
			S_VAR_GO:    div_go = 1'b1;
			S_VAR_WAIT:  sqrt_go = div_stat.done;
			S_DONE:      done = 1'b1;
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			sum_q   <= '0;
			drop_q  <= 1'b0;
			idx_q   <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (issue) idx_q <= idx_q + 1'b1;
			if (state_q == S_LOAD && take) begin
				if (room) begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q + SW'(sample);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (state_q == S_MEAN_WAIT) idx_q <= '0;
			if (state_q == S_DONE) begin
				count_q <= '0;
				sum_q   <= '0;
				drop_q  <= 1'b0;
			end
		end
	end

	// second pass datapath and result registers
	always_ff @(posedge clk) begin
		mag_s2 <= diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
		sq_s3  <= mag_s2 * mag_s2;
		if (state_q == S_MEAN_WAIT) begin
			acc_q <= '0;
			dev_q <= '0;
			if (div_stat.done) mean_q <= sum_q[SW-1] ? -q32 : q32;
		end else if (v_s3) begin
			acc_q <= acc_q + ACCW'(sq_s3);
		end
		if (state_q == S_SQRT_WAIT && sqrt_stat.done) begin
			dev_q <= (|root[RW-1:RESULT_W]) ? '1 : root[RESULT_W-1:0];
		end
	end

	assign mean_value   = mean_q;
	assign std_dev      = dev_q;
	assign sample_total = count_q;
	assign too_few      = count_q < CW'(2);
	assign overflowed   = drop_q;

	`SMSD_ASSERT(a_done_single, done |=> !done)
	`SMSD_ASSERT(a_last_goes_busy, (start && !busy && is_last) |=> busy)
	`SMSD_ASSERT(a_few_zero_dev, (done && too_few) |-> (std_dev == '0))
	`SMSD_ASSERT(a_units_exclusive, !(div_stat.busy && sqrt_stat.busy))
	`SMSD_ASSERT_RST(a_idle_in_reset, !arst_n |-> !done)

endmodule
